// ===== rtl/core/pidd_pkg.sv =====
// ----------------------------------------------------------------------------
// pidd_pkg
// Types and constants shared by the panel input decode and debounce block.
// ----------------------------------------------------------------------------
package pidd_pkg;

    localparam int DEBOUNCE_W       = 16;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd25;

    // APB address: byte address 4*i, one register
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;

    localparam logic [2:0] MODE_UNKNOWN = 3'd6;
    localparam logic [1:0] SUB_UNKNOWN  = 2'd3;
    localparam logic [6:0] LIMIT_MASK   = 7'h47;

    typedef struct packed {
        logic [5:0]  mode_pins;
        logic [7:0]  joystick_port;
        logic [4:0]  menu_port;
        logic [6:0]  limit_pins;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  submode;
        logic [3:0]  joystick;
        logic        rapid_pin;
        logic [3:0]  menu_nibble;
        logic        select_pin;
        logic [6:0]  limits;
        logic [31:0] last_change_ms;
        logic        changed;
    } t_out_item;

    // 22-bit snapshot: [2:0] mode ... [21:15] limits
    typedef struct packed {
        logic [6:0] limits;
        logic       select_pin;
        logic [3:0] menu_nibble;
        logic       rapid_pin;
        logic [3:0] joystick;
        logic [1:0] submode;
        logic [2:0] mode;
    } t_snap;

    typedef struct packed {
        logic initialised;
        logic changed;
    } t_dbn_status;

endpackage

// ===== rtl/core/pidd_decode.sv =====
// ----------------------------------------------------------------------------
// pidd_decode
// Turns raw panel pin samples into a snapshot.
// ----------------------------------------------------------------------------
module pidd_decode
    import pidd_pkg::*;
(
    input  t_in_item i_item,
    output t_snap    o_snap
);

    localparam logic [2:0] SUB_CODE_INTERNAL = 3'd6;
    localparam logic [2:0] SUB_CODE_MANUAL   = 3'd5;
    localparam logic [2:0] SUB_CODE_EXTERNAL = 3'd3;

    logic [5:0] low_pins;
    logic [2:0] mode;
    logic [1:0] submode;

    assign low_pins = ~i_item.mode_pins;

    // active-low one-hot switch; anything else is unknown
    always_comb begin
        mode = MODE_UNKNOWN;
        for (int i = 0; i < 6; i++) begin
            if (low_pins == (6'd1 << i)) begin
                mode = 3'(i);
            end
        end
    end

    always_comb begin
        unique case (i_item.joystick_port[7:5])
            SUB_CODE_INTERNAL: submode = 2'd0;
            SUB_CODE_MANUAL:   submode = 2'd1;
            SUB_CODE_EXTERNAL: submode = 2'd2;
            default:           submode = SUB_UNKNOWN;
        endcase
    end

    assign o_snap.mode        = mode;
    assign o_snap.submode     = submode;
    assign o_snap.joystick    = i_item.joystick_port[3:0];
    assign o_snap.rapid_pin   = i_item.joystick_port[4];
    assign o_snap.menu_nibble = i_item.menu_port[3:0];
    assign o_snap.select_pin  = i_item.menu_port[4];
    assign o_snap.limits      = i_item.limit_pins & LIMIT_MASK;

endmodule

// ===== rtl/core/pidd_debounce.sv =====
// ----------------------------------------------------------------------------
// pidd_debounce
// Pending/stable snapshot state and the hold timer. Produces the result for
// the item stepped in this cycle.
// ----------------------------------------------------------------------------
module pidd_debounce
    import pidd_pkg::*;
#(
    parameter int DBN_W = DEBOUNCE_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_snap            i_raw,
    input  logic [31:0]      i_now_ms,
    input  logic [DBN_W-1:0] i_debounce_ms,
    output t_out_item        o_result,
    output t_dbn_status      o_status
);

    logic        r_init;
    t_snap       r_stable,  n_stable;
    t_snap       r_pending, n_pending;
    logic [31:0] r_start,   n_start;
    logic [31:0] r_change,  n_change;
    logic        changed;
    logic [31:0] elapsed;
    logic        old_enough;

    assign elapsed    = i_now_ms - r_start;
    assign old_enough = elapsed >= 32'(i_debounce_ms);

    always_comb begin
        n_stable  = r_stable;
        n_pending = r_pending;
        n_start   = r_start;
        n_change  = r_change;
        changed   = 1'b0;
        if (!r_init) begin
            n_stable  = i_raw;
            n_pending = i_raw;
            n_start   = '0;
            n_change  = '0;
        end else if (i_raw != r_pending) begin
            n_pending = i_raw;
            n_start   = i_now_ms;
        end else if (old_enough && (r_pending != r_stable)) begin
            n_stable = r_pending;
            n_change = i_now_ms;
            changed  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b0;
        end else if (i_step) begin
            r_init <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_stable  <= n_stable;
            r_pending <= n_pending;
            r_start   <= n_start;
            r_change  <= n_change;
        end
    end

    assign o_result.mode           = n_stable.mode;
    assign o_result.submode        = n_stable.submode;
    assign o_result.joystick       = n_stable.joystick;
    assign o_result.rapid_pin      = n_stable.rapid_pin;
    assign o_result.menu_nibble    = n_stable.menu_nibble;
    assign o_result.select_pin     = n_stable.select_pin;
    assign o_result.limits         = n_stable.limits;
    assign o_result.last_change_ms = n_change;
    assign o_result.changed        = changed;

    assign o_status.initialised = r_init;
    assign o_status.changed     = changed;

endmodule

// ===== rtl/core/pidd_apb.sv =====
// ----------------------------------------------------------------------------
// pidd_apb
// APB register file: the debounce hold time.
// ----------------------------------------------------------------------------
module pidd_apb
    import pidd_pkg::*;
#(
    parameter int DBN_W = DEBOUNCE_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [DBN_W-1:0]      o_debounce_ms
);

    logic [DBN_W-1:0]     r_debounce;
    logic [CFG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DBN_W'(DEBOUNCE_RESET);
        end else if (psel && penable && pwrite && (reg_idx == REG_DEBOUNCE)) begin
            r_debounce <= pwdata[DBN_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE: prdata = 32'(r_debounce);
            default:      prdata = '0;
        endcase
    end

    assign o_debounce_ms = r_debounce;

endmodule

// ===== rtl/core/panel_input_decode_debounce.sv =====
// ----------------------------------------------------------------------------
// panel_input_decode_debounce
// Decodes panel pin samples into a snapshot and debounces it against a
// millisecond timestamp; one result beat per input beat.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                  payload
//  in       in   i_in_valid / o_in_ready    i_in_data  (t_in_item)
//  out      out  o_out_valid / i_out_ready  o_out_data (t_out_item)
//  cfg      in   APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One beat per cycle sustained while the output is ready; the input register
// feeds decode, timer compare and state update into the result register.
// The 32-bit elapsed-time subtract and compare sets the critical path.
// Reset clears the valid flags and the initialised flag; the hold time
// returns to 25 ms. A stalled output holds the result while one more input
// beat waits in the input register.
// ----------------------------------------------------------------------------
module panel_input_decode_debounce
    import pidd_pkg::*;
#(
    parameter int DBN_W = DEBOUNCE_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic             r_in_vld;
    t_in_item         r_in;
    logic             r_out_vld;
    t_out_item        r_out;
    logic             step;
    t_snap            raw;
    t_out_item        result;
    t_dbn_status      status;
    logic [DBN_W-1:0] debounce_ms;

    assign step       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || step;

    pidd_apb #(.DBN_W(DBN_W)) u_apb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_debounce_ms (debounce_ms)
    );

    pidd_decode u_decode (
        .i_item (r_in),
        .o_snap (raw)
    );

    pidd_debounce #(.DBN_W(DBN_W)) u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_raw         (raw),
        .i_now_ms      (r_in.now_ms),
        .i_debounce_ms (debounce_ms),
        .o_result      (result),
        .o_status      (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // a change beat carries the timestamp of the beat that caused it
    a_change_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && status.changed |=> o_out_data.last_change_ms == $past(r_in.now_ms))
        else $error("change time does not match causing beat");

    // the first beat after reset only initialises
    a_first_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && !status.initialised |=> !o_out_data.changed)
        else $error("change flagged on initialising beat");

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.mode <= MODE_UNKNOWN)
        else $error("mode code out of range");

    // input register never drops a beat while output is stalled
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !i_out_ready |=> r_in_vld && $stable(r_in))
        else $error("input register lost a beat under stall");

endmodule

// ===== test/panel_input_decode_debounce_tb.sv =====
// ----------------------------------------------------------------------------
// panel_input_decode_debounce_tb
// Drives panel pin samples with timestamps through the decode and debounce
// block and checks each result beat against an in-bench debounce tracker.
// The hold time is changed between phases over APB and read back. The random
// part is mostly press and bounce sequences, timed around the hold time.
// ----------------------------------------------------------------------------
module panel_input_decode_debounce_tb;
    import pidd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // submode pin codes and their decoded values
    localparam logic [2:0] CODE_INTERNAL = 3'd6;
    localparam logic [2:0] CODE_MANUAL   = 3'd5;
    localparam logic [2:0] CODE_EXTERNAL = 3'd3;
    localparam logic [1:0] SUB_INTERNAL  = 2'd0;
    localparam logic [1:0] SUB_MANUAL    = 2'd1;
    localparam logic [1:0] SUB_EXTERNAL  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] HOLD_ADDR = CFG_ADDR_W'({REG_DEBOUNCE, 2'b00});
    localparam int LONG_STALL = 100;

    class panel_debounce_tracker;
        logic [DEBOUNCE_W-1:0] hold_ms;
        t_snap                 stable_snap;
        t_snap                 pending_snap;
        logic [31:0]           pending_since;
        logic [31:0]           changed_at;
        bit                    primed;
        t_out_item             expected_snaps[$];
        int                    mismatches;

        function new();
            hold_ms       = DEBOUNCE_RESET;
            stable_snap   = '0;
            pending_snap  = '0;
            pending_since = '0;
            changed_at    = '0;
            primed        = 1'b0;
            mismatches    = 0;
        endfunction

        function void predict(t_in_item s);
            t_snap      raw;
            logic [5:0] low_pins;
            logic       flip;
            t_out_item  r;
            low_pins = ~s.mode_pins;
            raw.mode = MODE_UNKNOWN;
            for (int i = 0; i < 6; i++) begin
                if (low_pins == (6'd1 << i)) raw.mode = 3'(i);
            end
            case (s.joystick_port[7:5])
                CODE_INTERNAL: raw.submode = SUB_INTERNAL;
                CODE_MANUAL:   raw.submode = SUB_MANUAL;
                CODE_EXTERNAL: raw.submode = SUB_EXTERNAL;
                default:       raw.submode = SUB_UNKNOWN;
            endcase
            raw.joystick    = s.joystick_port[3:0];
            raw.rapid_pin   = s.joystick_port[4];
            raw.menu_nibble = s.menu_port[3:0];
            raw.select_pin  = s.menu_port[4];
            raw.limits      = s.limit_pins & LIMIT_MASK;

            flip = 1'b0;
            if (!primed) begin
                // first beat after reset loads both snapshots, times cleared
                stable_snap   = raw;
                pending_snap  = raw;
                pending_since = '0;
                changed_at    = '0;
                primed        = 1'b1;
            end else if (raw != pending_snap) begin
                pending_snap  = raw;
                pending_since = s.now_ms;
            end else if (32'(s.now_ms - pending_since) >= {16'b0, hold_ms}) begin
                if (pending_snap != stable_snap) begin
                    stable_snap = pending_snap;
                    changed_at  = s.now_ms;
                    flip        = 1'b1;
                end
            end

            r.mode           = stable_snap.mode;
            r.submode        = stable_snap.submode;
            r.joystick       = stable_snap.joystick;
            r.rapid_pin      = stable_snap.rapid_pin;
            r.menu_nibble    = stable_snap.menu_nibble;
            r.select_pin     = stable_snap.select_pin;
            r.limits         = stable_snap.limits;
            r.last_change_ms = changed_at;
            r.changed        = flip;
            expected_snaps.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_snapshot(t_out_item got);
            t_out_item want;
            if (expected_snaps.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                mismatches++;
                return;
            end
            want = expected_snaps.pop_front();
            compare_field("mode", want.mode, got.mode);
            compare_field("submode", want.submode, got.submode);
            compare_field("joystick", want.joystick, got.joystick);
            compare_field("rapid_pin", want.rapid_pin, got.rapid_pin);
            compare_field("menu_nibble", want.menu_nibble, got.menu_nibble);
            compare_field("select_pin", want.select_pin, got.select_pin);
            compare_field("limits", want.limits, got.limits);
            compare_field("last_change_ms", want.last_change_ms, got.last_change_ms);
            compare_field("changed", want.changed, got.changed);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    panel_debounce_tracker tracker = new();

    bit          tx_gaps_on;
    bit          rx_gaps_on;
    bit          rx_long_hold;
    int          items_sent;
    logic [31:0] clock_ms;

    panel_input_decode_debounce u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("panel_input_decode_debounce regression: fail");
        $finish;
    end

    // beats are taken from values sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_snapshot(o_out_data);
        if (i_rst_n && i_in_valid && o_in_ready) tracker.predict(i_in_data);
    end

    // receiver: random stalls, plus one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_long_hold) begin
                stall_left   = LONG_STALL;
                rx_long_hold = 1'b0;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(1, 12) - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic offer(input t_in_item s);
        if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // wait for an edge first so the last accepted beat is already in the queue
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_snaps.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_hold_time(input logic [DEBOUNCE_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HOLD_ADDR;
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.hold_ms = v;
        // read back straight after the write
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== 32'(v)) begin
            $error("debounce_ms readback: expected %0h, got %0h", 32'(v), prdata);
            tracker.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly a valid mode and submode, otherwise any pattern
    function automatic t_in_item random_pins();
        t_in_item   p;
        logic [2:0] code;
        if ($urandom_range(0, 4) != 0) begin
            p.mode_pins = 6'h3F ^ (6'd1 << $urandom_range(0, 5));
        end else begin
            p.mode_pins = 6'($urandom);
        end
        case ($urandom_range(0, 4))
            0:       code = CODE_INTERNAL;
            1:       code = CODE_MANUAL;
            2:       code = CODE_EXTERNAL;
            default: code = 3'($urandom);
        endcase
        p.joystick_port = {code, 5'($urandom)};
        p.menu_port     = 5'($urandom);
        p.limit_pins    = 7'($urandom);
        p.now_ms        = clock_ms;
        return p;
    endfunction

    // press sequences: optional bounce, then the new pins held around the hold time
    task automatic run_episodes(input int count);
        t_in_item    target;
        t_in_item    other;
        logic [31:0] t0;
        logic [31:0] span;
        int          stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            span = {16'b0, tracker.hold_ms};
            if ($urandom_range(0, 9) < 8) begin
                target = random_pins();
                repeat ($urandom_range(0, 3)) begin
                    other = target ^ (58'(1) << (32 + $urandom_range(0, 25)));
                    clock_ms += $urandom_range(0, span / 4 + 1);
                    other.now_ms = clock_ms;
                    offer(other);
                    clock_ms += $urandom_range(0, span / 4 + 1);
                    target.now_ms = clock_ms;
                    offer(target);
                end
                clock_ms += $urandom_range(0, 3);
                target.now_ms = clock_ms;
                offer(target);
                t0 = clock_ms;
                if ($urandom_range(0, 2) == 0) begin
                    // just short of the hold time, then exactly on it
                    target.now_ms = t0 + span - 1;
                    offer(target);
                    target.now_ms = t0 + span;
                    offer(target);
                    clock_ms = t0 + span;
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        clock_ms += $urandom_range(0, span / 2 + 1);
                        target.now_ms = clock_ms;
                        offer(target);
                    end
                end
            end else begin
                clock_ms = $urandom;
                offer(random_pins());
            end
        end
    endtask

    initial begin
        logic [2:0]            code_cycle [6];
        logic [DEBOUNCE_W-1:0] hold_plan [6];
        logic [5:0]            m;
        logic [7:0]            j;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_in_data    <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        tx_gaps_on   = 1'b1;
        rx_gaps_on   = 1'b1;
        rx_long_hold = 1'b0;
        items_sent   = 0;
        clock_ms     = '0;

        code_cycle = '{CODE_INTERNAL, CODE_MANUAL, CODE_EXTERNAL, 3'd0, 3'd7, CODE_INTERNAL};
        hold_plan  = '{16'd0, 16'd1, 16'hFFFF, 16'($urandom_range(2, 300)), DEBOUNCE_RESET,
                       16'($urandom)};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_hold_time(DEBOUNCE_RESET);

        // first beat initialises; unknown submode, mode 0, all other pins high
        offer({6'h3E, 8'hFF, 5'h1F, 7'h7F, 32'd12345});
        // feed mode, unused limit bits only; settles on exactly the hold time
        offer({6'h1F, 8'hA0, 5'h00, 7'h38, 32'd100});
        offer({6'h1F, 8'hA0, 5'h00, 7'h38, 32'd124});
        offer({6'h1F, 8'hA0, 5'h00, 7'h38, 32'd125});
        // no mode pin low; hold time crosses the timestamp wrap
        offer({6'h3F, 8'h1F, 5'h10, 7'h40, 32'hFFFF_FFF0});
        offer({6'h3F, 8'h1F, 5'h10, 7'h40, 32'h0000_0009});
        // all mode pins low, one short of the hold time
        offer({6'h00, 8'h60, 5'h0F, 7'h07, 32'hFFFF_FFFF});
        offer({6'h00, 8'h60, 5'h0F, 7'h07, 32'h0000_0017});
        for (int i = 0; i < 6; i++) begin
            m = 6'h3F ^ (6'd1 << i);
            j = {code_cycle[i], 1'(i), 4'(i * 3)};
            offer({m, j, 5'(i), 7'(i * 9), 32'(1000 * (i + 1))});
            offer({m, j, 5'(i), 7'(i * 9), 32'(1000 * (i + 1) + 25)});
        end
        // contact bounce on the select key
        offer({6'h3B, 8'hC5, 5'h15, 7'h2A, 32'd9000});
        offer({6'h3B, 8'hC5, 5'h05, 7'h2A, 32'd9010});
        offer({6'h3B, 8'hC5, 5'h15, 7'h2A, 32'd9020});
        offer({6'h3B, 8'hC5, 5'h15, 7'h2A, 32'd9044});
        offer({6'h3B, 8'hC5, 5'h15, 7'h2A, 32'd9045});

        for (int p = 0; p < 6; p++) begin
            wait_for_results();
            set_hold_time(hold_plan[p]);
            clock_ms   = $urandom;
            tx_gaps_on = (p != 5) && (p != 3);
            rx_gaps_on = (p != 5);
            if (p == 1) begin
                // long receiver hold while beats keep coming
                tx_gaps_on   = 1'b0;
                rx_long_hold = 1'b1;
                run_episodes(40);
                tx_gaps_on = 1'b1;
            end
            if (p == 2) begin
                run_episodes(130);
                wait_for_results();
                run_episodes(130);
            end else begin
                run_episodes(260);
            end
        end

        wait_for_results();
        repeat (5) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.expected_snaps.size() == 0) begin
            $display("panel_input_decode_debounce regression: pass");
        end else begin
            $display("panel_input_decode_debounce regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pidd_pkg.sv
rtl/core/pidd_decode.sv
rtl/core/pidd_debounce.sv
rtl/core/pidd_apb.sv
rtl/core/panel_input_decode_debounce.sv
test/panel_input_decode_debounce_tb.sv
